>>> rtl/text_mode_pixel_generator_core_macros.svh
// Assertion macros used by the checker of the pixel generator.
`ifndef TEXT_MODE_PIXEL_GENERATOR_CORE_MACROS_SVH
`define TEXT_MODE_PIXEL_GENERATOR_CORE_MACROS_SVH

// Plain property, sampled on the rising clock edge, ignored while in reset.
`define TMPG_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// A stalled transfer keeps its valid and its payload into the next cycle.
`define TMPG_ASSERT_HOLD(lbl, ck, rst_n, vld, stl, sig, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) \
		(vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

>>> rtl/tmpg_pkg.sv
`default_nettype none

package tmpg_pkg;

	localparam int DEF_TEXT_COLUMNS   = 53;
	localparam int DEF_LINE_PIXELS    = 320;
	localparam int DEF_FRAME_LINES    = 240;
	localparam int DEF_TEXT_RAM_DEPTH = 2048;

	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 11;
	localparam int DATA_W   = 16;
	localparam int COLOUR_W = 16;

	localparam int GLYPH_WIDTH  = 6;
	localparam int GLYPH_HEIGHT = 8;
	localparam int FONT_LINE_W  = 3;
	localparam int GLYPH_BIT_W  = 3;
	localparam int CODE_W       = 8;
	localparam int ATTR_W       = 8;
	localparam int NIBBLE_W     = 4;

	localparam int FONT_DEPTH    = 2048;
	localparam int FONT_AW       = 11;
	localparam int PALETTE_DEPTH = 16;
	localparam int PALETTE_AW    = 4;

	localparam logic [NIBBLE_W-1:0] NIBBLE_MASK   = 4'hF;
	localparam logic [COLOUR_W-1:0] BORDER_COLOUR = 16'h0000;

	localparam logic [CMD_W-1:0] CMD_WR_TEXT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_FONT    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR_PALETTE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_EMIT       = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] pixel;
		logic                line_end;
		logic                frame_end;
	} out_item_t;

	// Position of the pixel about to be emitted.
	typedef struct packed {
		logic                   border;
		logic                   line_end;
		logic                   frame_end;
		logic [FONT_LINE_W-1:0] font_line;
		logic [GLYPH_BIT_W-1:0] glyph_bit;
	} raster_t;

endpackage

`default_nettype wire

>>> rtl/text_mode_pixel_generator_core.sv
// Text-mode pixel generator: character cells in, RGB565 pixels out in raster order.
// Input channel (cmd_valid / cmd_stall / cmd): each transfer is one command.
// Write commands load the text RAM, the 6x8 font RAM or the 16-entry palette and
// give no result; an emit command gives one pixel on the output channel
// (pix_valid / pix_stall / pix) with line_end and frame_end flags.
// Path: a command is registered in stage 1, then a pixel passes the text RAM read,
// the font RAM read and the palette select, each behind a register.
// Throughput: one command per cycle while cmd_stall is low, writes and emits
// mixed freely; each store is written where it is read, so command order is kept.
// Reset: the raster position returns to the top left pixel and the pipeline
// empties; the text, font and palette contents are undefined until written.
// Stall: the output register holds its pixel while pix_stall is high; earlier
// stages keep taking commands into empty slots, and cmd_stall rises only once
// every stage is occupied.
`default_nettype none

module text_mode_pixel_generator_core
	import tmpg_pkg::*;
#(
	parameter int TEXT_COLUMNS   = DEF_TEXT_COLUMNS,
	parameter int LINE_PIXELS    = DEF_LINE_PIXELS,
	parameter int FRAME_LINES    = DEF_FRAME_LINES,
	parameter int TEXT_RAM_DEPTH = DEF_TEXT_RAM_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire in_item_t  cmd,
	output logic           pix_valid,
	input  wire logic      pix_stall,
	output out_item_t      pix
);

	localparam int TEXT_AW = $clog2(TEXT_RAM_DEPTH);
	localparam int CMP_W   = (TEXT_AW + 1 > ADDR_W) ? TEXT_AW + 1 : ADDR_W;

	// stage handshake
	logic take_s1;
	logic take_s2;
	logic take_s3;
	logic take_out;
	logic accept;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic result_valid_q;

	raster_t            rast_now;
	logic [TEXT_AW-1:0] cell_now;

	in_item_t           item_s1;
	raster_t            rast_s1;
	logic [TEXT_AW-1:0] cell_s1;

	in_item_t           item_s2;
	raster_t            rast_s2;
	logic [DATA_W-1:0]  text_rdata;

	in_item_t           item_s3;
	raster_t            rast_s3;
	logic [ATTR_W-1:0]  attr_s3;
	logic               code_nz_s3;
	logic [GLYPH_WIDTH-1:0] font_rdata;

	logic [COLOUR_W-1:0] palette_q [PALETTE_DEPTH];

	out_item_t result_q;

	logic                text_we;
	logic                font_we;
	logic                palette_we;
	logic                font_bit;
	logic [NIBBLE_W-1:0] colour_idx;

	assign take_out = !result_valid_q || !pix_stall;
	assign take_s3  = !valid_s3 || take_out;
	assign take_s2  = !valid_s2 || take_s3;
	assign take_s1  = !valid_s1 || take_s2;

	assign cmd_stall = !take_s1;
	assign accept    = cmd_valid && take_s1;

	tmpg_raster #(
		.TEXT_COLUMNS   (TEXT_COLUMNS),
		.LINE_PIXELS    (LINE_PIXELS),
		.FRAME_LINES    (FRAME_LINES),
		.TEXT_RAM_DEPTH (TEXT_RAM_DEPTH)
	) u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept && (cmd.command == CMD_EMIT)),
		.pos        (rast_now),
		.cell_index (cell_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= cmd_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
			if (take_s3) begin
				valid_s3 <= valid_s2;
			end
			if (take_out) begin
				result_valid_q <= valid_s3 && (item_s3.command == CMD_EMIT);
			end
		end
	end

	// Stage 1: command and raster position.
	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1 <= cmd;
			rast_s1 <= rast_now;
			cell_s1 <= cell_now;
		end
	end

	// Stage 1 to 2: text RAM write and cell read.
	assign text_we = take_s2 && valid_s1 && (item_s1.command == CMD_WR_TEXT) &&
	                 (CMP_W'(item_s1.address) < CMP_W'(TEXT_RAM_DEPTH));

	tmpg_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TEXT_RAM_DEPTH)
	) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (TEXT_AW'(item_s1.address)),
		.wdata (item_s1.write_data),
		.re    (take_s2 && valid_s1),
		.raddr (cell_s1),
		.rdata (text_rdata)
	);

	always_ff @(posedge clk) begin
		if (take_s2) begin
			item_s2 <= item_s1;
			rast_s2 <= rast_s1;
		end
	end

	// Stage 2 to 3: font RAM write and font line read.
	assign font_we = take_s3 && valid_s2 && (item_s2.command == CMD_WR_FONT);

	tmpg_ram #(
		.WIDTH (GLYPH_WIDTH),
		.DEPTH (FONT_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (item_s2.address),
		.wdata (item_s2.write_data[GLYPH_WIDTH-1:0]),
		.re    (take_s3 && valid_s2),
		.raddr ({text_rdata[CODE_W-1:0], rast_s2.font_line}),
		.rdata (font_rdata)
	);

	always_ff @(posedge clk) begin
		if (take_s3) begin
			item_s3    <= item_s2;
			rast_s3    <= rast_s2;
			attr_s3    <= text_rdata[DATA_W-1:CODE_W];
			code_nz_s3 <= (text_rdata[CODE_W-1:0] != '0);
		end
	end

	// Stage 3 to output: palette write and colour select.
	assign palette_we = take_out && valid_s3 && (item_s3.command == CMD_WR_PALETTE) &&
	                    (item_s3.address[ADDR_W-1:PALETTE_AW] == '0);

	always_ff @(posedge clk) begin
		if (palette_we) begin
			palette_q[item_s3.address[PALETTE_AW-1:0]] <= item_s3.write_data;
		end
	end

	assign font_bit   = font_rdata[rast_s3.glyph_bit];
	assign colour_idx = (code_nz_s3 && font_bit) ? (attr_s3[NIBBLE_W-1:0] & NIBBLE_MASK)
	                                             : (attr_s3[ATTR_W-1:NIBBLE_W] & NIBBLE_MASK);

	always_ff @(posedge clk) begin
		if (take_out) begin
			result_q.pixel     <= rast_s3.border ? BORDER_COLOUR : palette_q[colour_idx];
			result_q.line_end  <= rast_s3.line_end;
			result_q.frame_end <= rast_s3.frame_end;
		end
	end

	assign pix_valid = result_valid_q;
	assign pix       = result_q;

endmodule

`default_nettype wire

>>> rtl/tmpg_ram.sv
`default_nettype none

module tmpg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/tmpg_raster.sv
`default_nettype none

module tmpg_raster
	import tmpg_pkg::*;
#(
	parameter int TEXT_COLUMNS   = DEF_TEXT_COLUMNS,
	parameter int LINE_PIXELS    = DEF_LINE_PIXELS,
	parameter int FRAME_LINES    = DEF_FRAME_LINES,
	parameter int TEXT_RAM_DEPTH = DEF_TEXT_RAM_DEPTH,
	localparam int TEXT_AW = $clog2(TEXT_RAM_DEPTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	output raster_t                 pos,
	output logic      [TEXT_AW-1:0] cell_index
);

	localparam int X_W   = $clog2(LINE_PIXELS);
	localparam int Y_W   = $clog2(FRAME_LINES);
	localparam int COL_W = $clog2((LINE_PIXELS - 2) / GLYPH_WIDTH + 1);
	localparam int CMP_W = 8;
	localparam int SUM_W = TEXT_AW + 1;

	localparam logic [X_W-1:0]         X_LAST    = X_W'(LINE_PIXELS - 1);
	localparam logic [Y_W-1:0]         Y_LAST    = Y_W'(FRAME_LINES - 1);
	localparam logic [GLYPH_BIT_W-1:0] BIT_LAST  = GLYPH_BIT_W'(GLYPH_WIDTH - 1);
	localparam logic [FONT_LINE_W-1:0] ROW_LAST  = FONT_LINE_W'(GLYPH_HEIGHT - 1);
	localparam logic [SUM_W-1:0]       DEPTH_S   = SUM_W'(TEXT_RAM_DEPTH);
	localparam logic [SUM_W-1:0]       COLUMNS_S = SUM_W'(TEXT_COLUMNS);

	logic [X_W-1:0]         x_q;
	logic [Y_W-1:0]         y_q;
	logic [COL_W-1:0]       col_q;
	logic [GLYPH_BIT_W-1:0] bit_q;
	logic [TEXT_AW-1:0]     base_q;

	logic               last_x;
	logic               last_y;
	logic [SUM_W-1:0]   cell_sum;
	logic [SUM_W-1:0]   base_sum;
	logic [TEXT_AW-1:0] base_next;

	assign last_x = (x_q >= X_LAST);
	assign last_y = (y_q >= Y_LAST);

	// Cell index stays below twice the depth, so one subtract wraps it.
	assign cell_sum   = {1'b0, base_q} + SUM_W'(col_q);
	assign cell_index = (cell_sum >= DEPTH_S) ? TEXT_AW'(cell_sum - DEPTH_S)
	                                          : TEXT_AW'(cell_sum);

	assign base_sum  = {1'b0, base_q} + COLUMNS_S;
	assign base_next = (base_sum >= DEPTH_S) ? TEXT_AW'(base_sum - DEPTH_S)
	                                         : TEXT_AW'(base_sum);

	always_comb begin
		pos.border    = (x_q == '0) || last_x || (CMP_W'(col_q) >= CMP_W'(TEXT_COLUMNS));
		pos.line_end  = last_x;
		pos.frame_end = last_x && last_y;
		pos.font_line = y_q[FONT_LINE_W-1:0];
		pos.glyph_bit = bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			col_q  <= '0;
			bit_q  <= '0;
			base_q <= '0;
		end else if (step) begin
			if (last_x) begin
				x_q   <= '0;
				col_q <= '0;
				bit_q <= '0;
				if (last_y) begin
					y_q    <= '0;
					base_q <= '0;
				end else begin
					y_q <= y_q + 1'b1;
					if (y_q[FONT_LINE_W-1:0] == ROW_LAST) begin
						base_q <= base_next;
					end
				end
			end else begin
				x_q <= x_q + 1'b1;
				// the left border pixel leaves the glyph column where it is
				if (x_q != '0) begin
					if (bit_q == BIT_LAST) begin
						bit_q <= '0;
						col_q <= col_q + 1'b1;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/tmpg_checker.sv
`default_nettype none
`include "text_mode_pixel_generator_core_macros.svh"

module tmpg_checker
	import tmpg_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      cmd_valid,
	input wire logic      cmd_stall,
	input wire in_item_t  cmd,
	input wire logic      pix_valid,
	input wire logic      pix_stall,
	input wire out_item_t pix
);

	logic cmd_seen;

	assign cmd_seen = cmd_valid && !cmd_stall && (cmd.command == CMD_EMIT);

	`TMPG_ASSERT_HOLD(a_pix_hold, clk, arst_n, pix_valid, pix_stall, pix, "stalled pixel changed")
	`TMPG_ASSERT(a_frame_on_line, clk, arst_n, (pix_valid && pix.frame_end) |-> pix.line_end, "frame end off line end")
	`TMPG_ASSERT(a_line_end_black, clk, arst_n, (pix_valid && pix.line_end) |-> (pix.pixel == BORDER_COLOUR), "right border not black")
	`TMPG_ASSERT(a_no_early_pixel, clk, arst_n, ($past(!arst_n) && !cmd_seen) |=> !pix_valid, "pixel without an emit")

endmodule

bind text_mode_pixel_generator_core tmpg_checker u_tmpg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pix       (pix)
);

`default_nettype wire

>>> tb/sv/tb_text_mode_pixel_generator_core.sv
`timescale 1ns / 1ps

import tmpg_pkg::*;

// Tracks the text screen, font and palette as commands are taken, and holds the
// pixels that the emit commands should produce, oldest first.
class pixel_scoreboard;
	logic [COLOUR_W-1:0] text_cells [DEF_TEXT_RAM_DEPTH];
	logic [5:0]          font_rows [FONT_DEPTH];
	logic [COLOUR_W-1:0] palette [PALETTE_DEPTH];
	bit                  cell_set [DEF_TEXT_RAM_DEPTH];
	bit                  row_set [FONT_DEPTH];
	int unsigned         x_pos;
	int unsigned         y_pos;
	int unsigned         frame_wraps;
	out_item_t           pending_pixels [$];
	int unsigned         pixels_checked;
	int unsigned         mismatches;

	function new();
		x_pos = 0;
		y_pos = 0;
		frame_wraps = 0;
		pixels_checked = 0;
		mismatches = 0;
	endfunction

	// Text cell shown at a position, or -1 for the border.
	function int cell_index_at(int unsigned x, int unsigned y);
		int unsigned column;
		if (x == 0 || x >= DEF_LINE_PIXELS - 1)
			return -1;
		column = (x - 1) / GLYPH_WIDTH;
		if (column >= DEF_TEXT_COLUMNS)
			return -1;
		return ((y / GLYPH_HEIGHT) * DEF_TEXT_COLUMNS + column) % DEF_TEXT_RAM_DEPTH;
	endfunction

	function int unsigned font_index_for(logic [CODE_W-1:0] code, int unsigned y);
		return (code * GLYPH_HEIGHT + y % GLYPH_HEIGHT) % FONT_DEPTH;
	endfunction

	function logic [COLOUR_W-1:0] colour_at(int unsigned x, int unsigned y);
		int                  cell_idx;
		logic [COLOUR_W-1:0] attr_code;
		logic [5:0]          glyph;
		logic [3:0]          shade;
		cell_idx = cell_index_at(x, y);
		if (cell_idx < 0)
			return BORDER_COLOUR;
		attr_code = text_cells[cell_idx];
		glyph = font_rows[font_index_for(attr_code[7:0], y)];
		// code zero always shows the background, whatever its font row holds
		if (attr_code[7:0] != 0 && glyph[(x - 1) % GLYPH_WIDTH])
			shade = attr_code[11:8];
		else
			shade = attr_code[15:12];
		return palette[shade];
	endfunction

	function void note_command(in_item_t c);
		out_item_t want;
		case (c.command)
			CMD_WR_TEXT: begin
				if (c.address < DEF_TEXT_RAM_DEPTH) begin
					text_cells[c.address] = c.write_data;
					cell_set[c.address] = 1'b1;
				end
			end
			CMD_WR_FONT: begin
				font_rows[c.address % FONT_DEPTH] = c.write_data[5:0];
				row_set[c.address % FONT_DEPTH] = 1'b1;
			end
			CMD_WR_PALETTE: begin
				if (c.address < PALETTE_DEPTH)
					palette[c.address[PALETTE_AW-1:0]] = c.write_data;
			end
			CMD_EMIT: begin
				want.pixel = colour_at(x_pos, y_pos);
				want.line_end = (x_pos >= DEF_LINE_PIXELS - 1);
				want.frame_end = want.line_end && (y_pos >= DEF_FRAME_LINES - 1);
				pending_pixels.push_back(want);
				if (want.line_end) begin
					x_pos = 0;
					if (want.frame_end) begin
						y_pos = 0;
						frame_wraps++;
					end else begin
						y_pos++;
					end
				end else begin
					x_pos++;
				end
			end
			default: ;
		endcase
	endfunction

	function void report(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $time, what);
	endfunction

	function void check_pixel(out_item_t got);
		out_item_t want;
		if (pending_pixels.size() == 0) begin
			report($sformatf("pixel %h arrived with none outstanding", got.pixel));
			return;
		end
		want = pending_pixels.pop_front();
		if (got.pixel !== want.pixel)
			report($sformatf("pixel %0d colour expected %h got %h",
				pixels_checked, want.pixel, got.pixel));
		if (got.line_end !== want.line_end)
			report($sformatf("pixel %0d line_end expected %b got %b",
				pixels_checked, want.line_end, got.line_end));
		if (got.frame_end !== want.frame_end)
			report($sformatf("pixel %0d frame_end expected %b got %b",
				pixels_checked, want.frame_end, got.frame_end));
		pixels_checked++;
	endfunction
endclass

module tb_text_mode_pixel_generator_core;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 10;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	in_item_t  cmd;
	logic      pix_valid;
	logic      pix_stall;
	out_item_t pix;

	pixel_scoreboard sb = new();
	bit              idle_on;
	int unsigned     commands_sent;
	int unsigned     stall_hold;
	int unsigned     random_start;
	int unsigned     start_y;

	text_mode_pixel_generator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("run stopped after %0d cycles with %0d pixels outstanding",
			CYCLE_LIMIT, sb.pending_pixels.size());
		$display("Test completed with failures");
		$finish;
	end

	// Back-pressure on the pixel side in short random bursts.
	initial begin
		pix_stall = 1'b0;
		stall_hold = 0;
		forever begin
			@(negedge clk);
			if (stall_hold != 0)
				stall_hold--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				stall_hold = $urandom_range(1, 6);
			pix_stall <= (stall_hold != 0);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pix_valid && !pix_stall)
				sb.check_pixel(pix);
		end
	end

	function automatic logic [DATA_W-1:0] random_cell();
		logic [CODE_W-1:0] code;
		code = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		return {8'($urandom), code};
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send(input logic [CMD_W-1:0] op, input int unsigned addr,
			input logic [DATA_W-1:0] data);
		in_item_t item;
		item.command = op;
		item.address = 11'(addr);
		item.write_data = data;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(item);
		commands_sent++;
		@(negedge clk);
	endtask

	// Load whatever the next pixel reads and has not been written yet, then emit it.
	task automatic emit_pixel();
		int                 cell_idx;
		int unsigned        row_addr;
		logic [CODE_W-1:0]  code;
		cell_idx = sb.cell_index_at(sb.x_pos, sb.y_pos);
		if (cell_idx >= 0) begin
			if (!sb.cell_set[cell_idx])
				send(CMD_WR_TEXT, cell_idx, random_cell());
			code = sb.text_cells[cell_idx][7:0];
			row_addr = sb.font_index_for(code, sb.y_pos);
			if (!sb.row_set[row_addr])
				send(CMD_WR_FONT, row_addr, 16'($urandom));
		end
		send(CMD_EMIT, $urandom_range(0, 2047), 16'($urandom));
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (sb.pending_pixels.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		idle_on = 1'b1;
		commands_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < PALETTE_DEPTH; i++)
			send(CMD_WR_PALETTE, i,
				(i == 0) ? 16'h0000 : (i == 15) ? 16'hFFFF : 16'($urandom));
		// out of range palette indexes are dropped
		send(CMD_WR_PALETTE, PALETTE_DEPTH, 16'h1234);
		send(CMD_WR_PALETTE, 2047, 16'hFFFF);
		// font rows keep only their low six bits
		send(CMD_WR_FONT, 2047, 16'hFFFF);
		send(CMD_WR_TEXT, 2047, 16'hFFFF);
		send(CMD_WR_TEXT, 0, 16'hF0FF);
		send(CMD_WR_FONT, 255 * GLYPH_HEIGHT, 16'hFFEA);
		// code zero with a full font row still shows background
		send(CMD_WR_TEXT, 1, 16'h0F00);
		send(CMD_WR_FONT, 0, 16'hFFFF);
		repeat (8) emit_pixel();
		wait_drained();

		random_start = commands_sent;
		while (commands_sent < random_start + RANDOM_ITEMS) begin
			idle_on = (((commands_sent - random_start) / 150) % 3) != 2;
			if (commands_sent - random_start == RANDOM_ITEMS / 2)
				wait_drained();
			case ($urandom_range(0, 9))
				0, 1: begin
					if ($urandom_range(0, 3) == 0)
						send(CMD_WR_TEXT, $urandom_range(0, 2047), random_cell());
					else
						send(CMD_WR_TEXT, (sb.y_pos / GLYPH_HEIGHT) * DEF_TEXT_COLUMNS
							+ $urandom_range(0, DEF_TEXT_COLUMNS - 1), random_cell());
				end
				2: send(CMD_WR_FONT, $urandom_range(0, 2047), 16'($urandom));
				3: begin
					if ($urandom_range(0, 3) == 0)
						send(CMD_WR_PALETTE, $urandom_range(PALETTE_DEPTH, 2047),
							16'($urandom));
					else
						send(CMD_WR_PALETTE, $urandom_range(0, PALETTE_DEPTH - 1),
							16'($urandom));
				end
				default: emit_pixel();
			endcase
		end

		// run on without gaps through the next line end and a little past it
		idle_on = 1'b0;
		start_y = sb.y_pos;
		while (sb.y_pos == start_y || sb.x_pos < 8)
			emit_pixel();

		cmd_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d pixels checked over %0d frame wrap(s)",
			commands_sent, sb.pixels_checked, sb.frame_wraps);
		$display("writes to every store, dropped palette and font bits, random gaps and stalls;"
			, " %0d mismatches", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
